### rtl/core/des_pkg.sv
// DES package: permutation tables, S-boxes and bit-level helper functions.
// Shared by the key schedule, the round logic and the top level. No dependencies.

package des_pkg;

  // Table entries are the 1-based bit positions of the standard tables.
  typedef logic [6:0] pos_t;

  // All sixteen round subkeys, round 1 in index 0.
  typedef logic [15:0][47:0] subkey_arr_t;

  localparam int ROUNDS = 16;

  localparam pos_t IP_TAB [64] = '{
    7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
    7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
    7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
    7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
    7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
    7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7
  };

  localparam pos_t FP_TAB [64] = '{
    7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
    7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
    7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
    7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
    7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
    7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
    7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
    7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25
  };

  localparam pos_t E_TAB [48] = '{
    7'd32, 7'd1,  7'd2,  7'd3,  7'd4,  7'd5,
    7'd4,  7'd5,  7'd6,  7'd7,  7'd8,  7'd9,
    7'd8,  7'd9,  7'd10, 7'd11, 7'd12, 7'd13,
    7'd12, 7'd13, 7'd14, 7'd15, 7'd16, 7'd17,
    7'd16, 7'd17, 7'd18, 7'd19, 7'd20, 7'd21,
    7'd20, 7'd21, 7'd22, 7'd23, 7'd24, 7'd25,
    7'd24, 7'd25, 7'd26, 7'd27, 7'd28, 7'd29,
    7'd28, 7'd29, 7'd30, 7'd31, 7'd32, 7'd1
  };

  localparam pos_t P_TAB [32] = '{
    7'd16, 7'd7,  7'd20, 7'd21, 7'd29, 7'd12, 7'd28, 7'd17,
    7'd1,  7'd15, 7'd23, 7'd26, 7'd5,  7'd18, 7'd31, 7'd10,
    7'd2,  7'd8,  7'd24, 7'd14, 7'd32, 7'd27, 7'd3,  7'd9,
    7'd19, 7'd13, 7'd30, 7'd6,  7'd22, 7'd11, 7'd4,  7'd25
  };

  localparam pos_t PC1_TAB [56] = '{
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
    7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
    7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
    7'd60, 7'd52, 7'd44, 7'd36,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7,
    7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
    7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
    7'd28, 7'd20, 7'd12, 7'd4
  };

  localparam pos_t PC2_TAB [48] = '{
    7'd14, 7'd17, 7'd11, 7'd24, 7'd1,  7'd5,  7'd3,  7'd28,
    7'd15, 7'd6,  7'd21, 7'd10, 7'd23, 7'd19, 7'd12, 7'd4,
    7'd26, 7'd8,  7'd16, 7'd7,  7'd27, 7'd20, 7'd13, 7'd2,
    7'd41, 7'd52, 7'd31, 7'd37, 7'd47, 7'd55, 7'd30, 7'd40,
    7'd51, 7'd45, 7'd33, 7'd48, 7'd44, 7'd49, 7'd39, 7'd56,
    7'd34, 7'd53, 7'd46, 7'd42, 7'd50, 7'd36, 7'd29, 7'd32
  };

  // Per-round left rotation of the C and D halves; the amounts accumulate.
  localparam logic [1:0] ROT_TAB [16] = '{
    2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
    2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1
  };

  // S-boxes, indexed by {row, column}.
  localparam logic [3:0] SBOX [8][64] = '{
    '{4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
      4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7,
      4'd0, 4'd15, 4'd7, 4'd4, 4'd14, 4'd2, 4'd13, 4'd1,
      4'd10, 4'd6, 4'd12, 4'd11, 4'd9, 4'd5, 4'd3, 4'd8,
      4'd4, 4'd1, 4'd14, 4'd8, 4'd13, 4'd6, 4'd2, 4'd11,
      4'd15, 4'd12, 4'd9, 4'd7, 4'd3, 4'd10, 4'd5, 4'd0,
      4'd15, 4'd12, 4'd8, 4'd2, 4'd4, 4'd9, 4'd1, 4'd7,
      4'd5, 4'd11, 4'd3, 4'd14, 4'd10, 4'd0, 4'd6, 4'd13},
    '{4'd15, 4'd1, 4'd8, 4'd14, 4'd6, 4'd11, 4'd3, 4'd4,
      4'd9, 4'd7, 4'd2, 4'd13, 4'd12, 4'd0, 4'd5, 4'd10,
      4'd3, 4'd13, 4'd4, 4'd7, 4'd15, 4'd2, 4'd8, 4'd14,
      4'd12, 4'd0, 4'd1, 4'd10, 4'd6, 4'd9, 4'd11, 4'd5,
      4'd0, 4'd14, 4'd7, 4'd11, 4'd10, 4'd4, 4'd13, 4'd1,
      4'd5, 4'd8, 4'd12, 4'd6, 4'd9, 4'd3, 4'd2, 4'd15,
      4'd13, 4'd8, 4'd10, 4'd1, 4'd3, 4'd15, 4'd4, 4'd2,
      4'd11, 4'd6, 4'd7, 4'd12, 4'd0, 4'd5, 4'd14, 4'd9},
    '{4'd10, 4'd0, 4'd9, 4'd14, 4'd6, 4'd3, 4'd15, 4'd5,
      4'd1, 4'd13, 4'd12, 4'd7, 4'd11, 4'd4, 4'd2, 4'd8,
      4'd13, 4'd7, 4'd0, 4'd9, 4'd3, 4'd4, 4'd6, 4'd10,
      4'd2, 4'd8, 4'd5, 4'd14, 4'd12, 4'd11, 4'd15, 4'd1,
      4'd13, 4'd6, 4'd4, 4'd9, 4'd8, 4'd15, 4'd3, 4'd0,
      4'd11, 4'd1, 4'd2, 4'd12, 4'd5, 4'd10, 4'd14, 4'd7,
      4'd1, 4'd10, 4'd13, 4'd0, 4'd6, 4'd9, 4'd8, 4'd7,
      4'd4, 4'd15, 4'd14, 4'd3, 4'd11, 4'd5, 4'd2, 4'd12},
    '{4'd7, 4'd13, 4'd14, 4'd3, 4'd0, 4'd6, 4'd9, 4'd10,
      4'd1, 4'd2, 4'd8, 4'd5, 4'd11, 4'd12, 4'd4, 4'd15,
      4'd13, 4'd8, 4'd11, 4'd5, 4'd6, 4'd15, 4'd0, 4'd3,
      4'd4, 4'd7, 4'd2, 4'd12, 4'd1, 4'd10, 4'd14, 4'd9,
      4'd10, 4'd6, 4'd9, 4'd0, 4'd12, 4'd11, 4'd7, 4'd13,
      4'd15, 4'd1, 4'd3, 4'd14, 4'd5, 4'd2, 4'd8, 4'd4,
      4'd3, 4'd15, 4'd0, 4'd6, 4'd10, 4'd1, 4'd13, 4'd8,
      4'd9, 4'd4, 4'd5, 4'd11, 4'd12, 4'd7, 4'd2, 4'd14},
    '{4'd2, 4'd12, 4'd4, 4'd1, 4'd7, 4'd10, 4'd11, 4'd6,
      4'd8, 4'd5, 4'd3, 4'd15, 4'd13, 4'd0, 4'd14, 4'd9,
      4'd14, 4'd11, 4'd2, 4'd12, 4'd4, 4'd7, 4'd13, 4'd1,
      4'd5, 4'd0, 4'd15, 4'd10, 4'd3, 4'd9, 4'd8, 4'd6,
      4'd4, 4'd2, 4'd1, 4'd11, 4'd10, 4'd13, 4'd7, 4'd8,
      4'd15, 4'd9, 4'd12, 4'd5, 4'd6, 4'd3, 4'd0, 4'd14,
      4'd11, 4'd8, 4'd12, 4'd7, 4'd1, 4'd14, 4'd2, 4'd13,
      4'd6, 4'd15, 4'd0, 4'd9, 4'd10, 4'd4, 4'd5, 4'd3},
    '{4'd12, 4'd1, 4'd10, 4'd15, 4'd9, 4'd2, 4'd6, 4'd8,
      4'd0, 4'd13, 4'd3, 4'd4, 4'd14, 4'd7, 4'd5, 4'd11,
      4'd10, 4'd15, 4'd4, 4'd2, 4'd7, 4'd12, 4'd9, 4'd5,
      4'd6, 4'd1, 4'd13, 4'd14, 4'd0, 4'd11, 4'd3, 4'd8,
      4'd9, 4'd14, 4'd15, 4'd5, 4'd2, 4'd8, 4'd12, 4'd3,
      4'd7, 4'd0, 4'd4, 4'd10, 4'd1, 4'd13, 4'd11, 4'd6,
      4'd4, 4'd3, 4'd2, 4'd12, 4'd9, 4'd5, 4'd15, 4'd10,
      4'd11, 4'd14, 4'd1, 4'd7, 4'd6, 4'd0, 4'd8, 4'd13},
    '{4'd4, 4'd11, 4'd2, 4'd14, 4'd15, 4'd0, 4'd8, 4'd13,
      4'd3, 4'd12, 4'd9, 4'd7, 4'd5, 4'd10, 4'd6, 4'd1,
      4'd13, 4'd0, 4'd11, 4'd7, 4'd4, 4'd9, 4'd1, 4'd10,
      4'd14, 4'd3, 4'd5, 4'd12, 4'd2, 4'd15, 4'd8, 4'd6,
      4'd1, 4'd4, 4'd11, 4'd13, 4'd12, 4'd3, 4'd7, 4'd14,
      4'd10, 4'd15, 4'd6, 4'd8, 4'd0, 4'd5, 4'd9, 4'd2,
      4'd6, 4'd11, 4'd13, 4'd8, 4'd1, 4'd4, 4'd10, 4'd7,
      4'd9, 4'd5, 4'd0, 4'd15, 4'd14, 4'd2, 4'd3, 4'd12},
    '{4'd13, 4'd2, 4'd8, 4'd4, 4'd6, 4'd15, 4'd11, 4'd1,
      4'd10, 4'd9, 4'd3, 4'd14, 4'd5, 4'd0, 4'd12, 4'd7,
      4'd1, 4'd15, 4'd13, 4'd8, 4'd10, 4'd3, 4'd7, 4'd4,
      4'd12, 4'd5, 4'd6, 4'd11, 4'd0, 4'd14, 4'd9, 4'd2,
      4'd7, 4'd11, 4'd4, 4'd1, 4'd9, 4'd12, 4'd14, 4'd2,
      4'd0, 4'd6, 4'd10, 4'd13, 4'd15, 4'd3, 4'd5, 4'd8,
      4'd2, 4'd1, 4'd14, 4'd7, 4'd4, 4'd10, 4'd8, 4'd13,
      4'd15, 4'd12, 4'd9, 4'd0, 4'd3, 4'd5, 4'd6, 4'd11}
  };

  // Output bit i takes input bit (table entry - 1); bit 0 is the first DES bit.
  function automatic logic [63:0] perm_ip(input logic [63:0] x);
    logic [63:0] y;
    for (int i = 0; i < 64; i++) begin
      y[i] = x[6'(IP_TAB[i] - 7'd1)];
    end
    return y;
  endfunction

  function automatic logic [63:0] perm_fp(input logic [63:0] x);
    logic [63:0] y;
    for (int i = 0; i < 64; i++) begin
      y[i] = x[6'(FP_TAB[i] - 7'd1)];
    end
    return y;
  endfunction

  function automatic logic [47:0] perm_e(input logic [31:0] x);
    logic [47:0] y;
    for (int i = 0; i < 48; i++) begin
      y[i] = x[5'(E_TAB[i] - 7'd1)];
    end
    return y;
  endfunction

  function automatic logic [31:0] perm_p(input logic [31:0] x);
    logic [31:0] y;
    for (int i = 0; i < 32; i++) begin
      y[i] = x[5'(P_TAB[i] - 7'd1)];
    end
    return y;
  endfunction

  function automatic logic [55:0] perm_pc1(input logic [63:0] x);
    logic [55:0] y;
    for (int i = 0; i < 56; i++) begin
      y[i] = x[6'(PC1_TAB[i] - 7'd1)];
    end
    return y;
  endfunction

  function automatic logic [47:0] perm_pc2(input logic [55:0] x);
    logic [47:0] y;
    for (int i = 0; i < 48; i++) begin
      y[i] = x[6'(PC2_TAB[i] - 7'd1)];
    end
    return y;
  endfunction

  // Rotation toward the first bit, which is a right rotate in bit index.
  function automatic logic [27:0] rot28(input logic [27:0] v, input logic [1:0] s);
    return (s == 2'd1) ? {v[0], v[27:1]} : {v[1:0], v[27:2]};
  endfunction

endpackage

### rtl/core/des_key_sched.sv
// DES key schedule: PC-1, cumulative half rotations and PC-2 for all sixteen rounds.
// Pure bit routing from the key register. Depends on des_pkg.

module des_key_sched import des_pkg::*; (
  input  logic [63:0]  cipher_key,
  output subkey_arr_t  subkey
);

  logic [27:0] c_half [ROUNDS+1];
  logic [27:0] d_half [ROUNDS+1];
  logic [55:0] cd;

  assign cd        = perm_pc1(cipher_key);
  assign c_half[0] = cd[27:0];
  assign d_half[0] = cd[55:28];

  for (genvar g = 0; g < ROUNDS; g++) begin : g_round
    assign c_half[g+1] = rot28(c_half[g], ROT_TAB[g]);
    assign d_half[g+1] = rot28(d_half[g], ROT_TAB[g]);
    assign subkey[g]   = perm_pc2({d_half[g+1], c_half[g+1]});
  end

endmodule

### rtl/core/des_round.sv
// One DES Feistel round: expansion, subkey mix, S-boxes, P permutation and half swap.
// Depends on des_pkg.

module des_round import des_pkg::*; (
  input  logic [31:0] l_in,
  input  logic [31:0] r_in,
  input  logic [47:0] round_key,
  output logic [31:0] l_out,
  output logic [31:0] r_out
);

  logic [47:0] mixed;
  logic [31:0] sbox_out;

  assign mixed = perm_e(r_in) ^ round_key;

  always_comb begin
    logic [5:0] b;
    logic [3:0] v;
    sbox_out = '0;
    for (int i = 0; i < 8; i++) begin
      b = mixed[6*i +: 6];
      // Row comes from the outer bits, column from the inner four.
      v = SBOX[i][{b[0], b[5], b[1], b[2], b[3], b[4]}];
      sbox_out[4*i +: 4] = {v[0], v[1], v[2], v[3]};
    end
  end

  assign l_out = r_in;
  assign r_out = l_in ^ perm_p(sbox_out);

endmodule

### rtl/core/des_block_cipher_core.sv
// DES block cipher core: key register, input register, sixteen rounds, result register.
//
// Usage:
//   The key is loaded through cfg_we / cfg_data and must only change while no
//   beat is in flight. Input beats (operation, data_block)
//   move on in_valid / in_ready; operation 0 encrypts and 1 decrypts, which only
//   reverses the subkey order. Result beats (result_block) leave on
//   out_valid / out_ready.
//   A beat enters the input register at the edge that accepts it and passes
//   through the sixteen rounds into the result register, which raises
//   out_valid; a stalled result register holds it back in the input register.
//   Throughput: one block per cycle while the receiver does not stall; the depth
//   of the sixteen chained rounds between the two registers sets the clock period.
//   When the receiver stalls, the result register holds its beat and the
//   input register fills behind it; in_ready drops only once both are full,
//   and it follows out_ready again in the same cycle the stall ends.
//   Reset clears both valid flags and the key to zero.
// Depends on des_pkg, des_key_sched and des_round.

module des_block_cipher_core import des_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [63:0] data_block,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] result_block
);

  logic [63:0]  cipher_key;
  logic         stage_valid;
  logic         stage_op;
  logic [63:0]  stage_data;
  logic         out_load;
  subkey_arr_t  subkey;
  logic [47:0]  round_key [ROUNDS];
  logic [31:0]  l_half [ROUNDS+1];
  logic [31:0]  r_half [ROUNDS+1];
  logic [63:0]  ip_block;

  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_key <= '0;
    end else if (cfg_we) begin
      cipher_key <= cfg_data;
    end
  end

  // The result register takes a new beat when it is empty or being drained.
  assign out_load = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_op   <= operation;
      stage_data <= data_block;
    end
  end

  des_key_sched u_key_sched (
    .cipher_key (cipher_key),
    .subkey     (subkey)
  );

  assign ip_block  = perm_ip(stage_data);
  assign l_half[0] = ip_block[31:0];
  assign r_half[0] = ip_block[63:32];

  for (genvar g = 0; g < ROUNDS; g++) begin : g_round
    assign round_key[g] = stage_op ? subkey[ROUNDS-1-g] : subkey[g];

    des_round u_round (
      .l_in      (l_half[g]),
      .r_in      (r_half[g]),
      .round_key (round_key[g]),
      .l_out     (l_half[g+1]),
      .r_out     (r_half[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // The final swap of the halves is folded into the concatenation order.
  always_ff @(posedge clk) begin
    if (out_load) begin
      result_block <= perm_fp({l_half[ROUNDS], r_half[ROUNDS]});
    end
  end

endmodule

### rtl/core/des_block_cipher_checker.sv
// Port-level checker for des_block_cipher_core, bound to every instance.
// Depends on des_block_cipher_core only through the bind below.

module des_block_cipher_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] result_block
);

  // No result beat may appear right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // A stalled result beat holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_block))
    else $error("stalled result beat changed");

  // A draining receiver never blocks the input side.
  a_no_bubble: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("in_ready low while out_ready high");

  // An accepted beat moves from the input register into the result register when out_ready is high, raising out_valid.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) ##1 out_ready |=> out_valid)
    else $error("accepted beat did not reach the output");

endmodule

bind des_block_cipher_core des_block_cipher_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .result_block (result_block)
);
